>>> hdl/assert_macros.svh
// assertion macros included by the rtl top level of the wide alu
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock outside reset
`define WSIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define WSIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/wsia_pkg.sv
// shared constants, mode codes and pipeline sideband type of the wide alu
`default_nettype none
package wsia_pkg;
  localparam int Width = 128;
  localparam int HalfW = 64;
  localparam int ShW = 7;
  localparam int ModeW = 4;
  localparam int DivSteps = Width;

  localparam logic [ModeW-1:0] ModeAdd = 4'd0;
  localparam logic [ModeW-1:0] ModeSub = 4'd1;
  localparam logic [ModeW-1:0] ModeMul = 4'd2;
  localparam logic [ModeW-1:0] ModeDiv = 4'd3;
  localparam logic [ModeW-1:0] ModeRem = 4'd4;
  localparam logic [ModeW-1:0] ModeNeg = 4'd5;
  localparam logic [ModeW-1:0] ModeAnd = 4'd6;
  localparam logic [ModeW-1:0] ModeOr  = 4'd7;
  localparam logic [ModeW-1:0] ModeXor = 4'd8;
  localparam logic [ModeW-1:0] ModeNot = 4'd9;
  localparam logic [ModeW-1:0] ModeShl = 4'd10;
  localparam logic [ModeW-1:0] ModeSar = 4'd11;
  localparam logic [ModeW-1:0] ModeRev = 4'd12;
  localparam logic [ModeW-1:0] ModeCmp = 4'd13;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [Width-1:0] res;
    logic             eq;
    logic             gt;
    logic             lt;
    logic             dz;
    logic             na;
    logic             nb;
  } side_t;
endpackage
`default_nettype wire

>>> hdl/wsia_div.sv
// pipelined restoring divider, one quotient bit per stage, sideband carried along
`default_nettype none
module wsia_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire wsia_pkg::side_t             in_side,
  input  wire logic [wsia_pkg::Width-1:0]  in_n,
  input  wire logic [wsia_pkg::Width-1:0]  in_d,
  output logic                             out_valid,
  output wsia_pkg::side_t                  out_side,
  output logic [wsia_pkg::Width-1:0]       out_q,
  output logic [wsia_pkg::Width-1:0]       out_r
);
  localparam int W = wsia_pkg::Width;
  localparam int N = wsia_pkg::DivSteps;

  logic             valid [N];
  wsia_pkg::side_t  side  [N];
  logic [W-1:0]     rem   [N];
  logic [W-1:0]     qn    [N];
  logic [W-1:0]     dd    [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic            valid_in;
    wsia_pkg::side_t side_in;
    logic [W-1:0]    rem_in;
    logic [W-1:0]    qn_in;
    logic [W-1:0]    d_in;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign valid_in = in_valid;
      assign side_in  = in_side;
      assign rem_in   = '0;
      assign qn_in    = in_n;
      assign d_in     = in_d;
    end else begin : g_next
      assign valid_in = valid[k-1];
      assign side_in  = side[k-1];
      assign rem_in   = rem[k-1];
      assign qn_in    = qn[k-1];
      assign d_in     = dd[k-1];
    end

    // bring down the next dividend bit and try the subtract
    assign trial = {rem_in, qn_in[W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = ~diff[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side_in;
        rem[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
        qn[k]   <= {qn_in[W-2:0], ge};
        dd[k]   <= d_in;
      end
    end
  end

  assign out_valid = valid[N-1];
  assign out_side  = side[N-1];
  assign out_q     = qn[N-1];
  assign out_r     = rem[N-1];
endmodule
`default_nettype wire

>>> hdl/wide_signed_integer_alu_unit.sv
// an accepted input item is registered through stages 1 to 4, the divide stages and the output register
// throughput: one item per cycle while the output does not stall; the 128 restoring divide stages set the depth
// every mode goes through the same pipeline, so results leave in input order
// a stall on the output freezes the whole pipeline and drops s_tready
// rst (synchronous, active high) clears all stage valid bits; data is not reset
`default_nettype none
`include "assert_macros.svh"
module wide_signed_integer_alu_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // a_high[63:0], a_low[127:64], b_high[191:128], b_low[255:192], shift_count[262:256]
  input  wire logic [263:0] s_tdata,
  // mode[3:0]
  input  wire logic [3:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // result_high[63:0], result_low[127:64], is_equal[128], is_greater[129],
  // is_less[130], divide_by_zero[131], result_zero[132]
  output logic [135:0]      m_tdata
);
  localparam int W = wsia_pkg::Width;
  localparam int H = wsia_pkg::HalfW;

  logic en;

  // stage 1: input capture
  logic                        v1;
  logic [wsia_pkg::ModeW-1:0]  mode1;
  logic [W-1:0]                a1;
  logic [W-1:0]                b1;
  logic [wsia_pkg::ShW-1:0]    sc1;

  // stage 2: simple ops, operand magnitudes, partial products
  logic                        v2;
  wsia_pkg::side_t             side2;
  logic [W-1:0]                n2, d2;
  logic [63:0] p00, p01, p10, p02, p11, p20, p03, p12, p21, p30;

  // stage 3: partial product sums
  logic                        v3;
  wsia_pkg::side_t             side3;
  logic [W-1:0]                n3, d3, sa3, sb3;

  // stage 4: product merged
  logic                        v4;
  wsia_pkg::side_t             side4;
  wsia_pkg::side_t             side4_next;
  logic [W-1:0]                n4, d4;

  logic                        vd;
  wsia_pkg::side_t             sided;
  logic [W-1:0]                qd, rd;

  wsia_pkg::side_t             side2_next;
  logic [W-1:0]                rev;
  logic [W-1:0]                res_next;
  logic [W-1:0]                res;
  logic                        eq, gt, lt, dz, rz;

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      m_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= s_tuser;
      a1    <= {s_tdata[63:0], s_tdata[127:64]};
      b1    <= {s_tdata[191:128], s_tdata[255:192]};
      sc1   <= s_tdata[262:256];
    end
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      rev[i] = a1[W-1-i];
    end
  end

  always_comb begin
    side2_next      = '0;
    side2_next.mode = mode1;
    side2_next.na   = a1[W-1];
    side2_next.nb   = b1[W-1];
    case (mode1)
      wsia_pkg::ModeAdd: side2_next.res = a1 + b1;
      wsia_pkg::ModeSub: side2_next.res = a1 - b1;
      wsia_pkg::ModeDiv,
      wsia_pkg::ModeRem: side2_next.dz = (b1 == '0);
      wsia_pkg::ModeNeg: side2_next.res = -a1;
      wsia_pkg::ModeAnd: side2_next.res = a1 & b1;
      wsia_pkg::ModeOr:  side2_next.res = a1 | b1;
      wsia_pkg::ModeXor: side2_next.res = a1 ^ b1;
      wsia_pkg::ModeNot: side2_next.res = ~a1;
      wsia_pkg::ModeShl: side2_next.res = a1 << sc1;
      wsia_pkg::ModeSar: side2_next.res = $signed(a1) >>> sc1;
      wsia_pkg::ModeRev: side2_next.res = rev;
      wsia_pkg::ModeCmp: begin
        side2_next.eq = (a1 == b1);
        side2_next.lt = ($signed(a1) < $signed(b1));
        side2_next.gt = ($signed(b1) < $signed(a1));
      end
      default: side2_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side2_next;
      n2    <= a1[W-1] ? -a1 : a1;
      d2    <= b1[W-1] ? -b1 : b1;
      // only products that reach the low 128 bits
      p00 <= 64'(a1[31:0])  * 64'(b1[31:0]);
      p01 <= 64'(a1[31:0])  * 64'(b1[63:32]);
      p10 <= 64'(a1[63:32]) * 64'(b1[31:0]);
      p02 <= 64'(a1[31:0])  * 64'(b1[95:64]);
      p11 <= 64'(a1[63:32]) * 64'(b1[63:32]);
      p20 <= 64'(a1[95:64]) * 64'(b1[31:0]);
      p03 <= 64'(a1[31:0])  * 64'(b1[127:96]);
      p12 <= 64'(a1[63:32]) * 64'(b1[95:64]);
      p21 <= 64'(a1[95:64]) * 64'(b1[63:32]);
      p30 <= 64'(a1[127:96]) * 64'(b1[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side2;
      n3    <= n2;
      d3    <= d2;
      sa3   <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0};
      sb3   <= {64'(p02 + p11 + p20), 64'd0}
             + {32'(p03[31:0] + p12[31:0] + p21[31:0] + p30[31:0]), 96'd0};
    end
  end

  always_comb begin
    side4_next = side3;
    if (side3.mode == wsia_pkg::ModeMul) begin
      side4_next.res = sa3 + sb3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side4_next;
      n4 <= n3;
      d4 <= d3;
    end
  end

  wsia_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_side   (side4),
    .in_n      (n4),
    .in_d      (d4),
    .out_valid (vd),
    .out_side  (sided),
    .out_q     (qd),
    .out_r     (rd)
  );

  // sign fix-up of quotient and remainder, zero on divide by zero; other modes pass their result
  always_comb begin
    case (sided.mode)
      wsia_pkg::ModeDiv: res_next = sided.dz ? '0 : ((sided.na ^ sided.nb) ? -qd : qd);
      wsia_pkg::ModeRem: res_next = sided.dz ? '0 : (sided.na ? -rd : rd);
      default:           res_next = sided.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
      eq  <= sided.eq;
      gt  <= sided.gt;
      lt  <= sided.lt;
      dz  <= sided.dz;
      rz  <= (res_next == '0);
    end
  end

  assign m_tdata = {3'b000, rz, dz, lt, gt, eq, res[H-1:0], res[W-1:H]};

  `WSIA_ASSERT(a_cmp_onehot, !m_tvalid || $onehot0(m_tdata[130:128]),
    "more than one compare flag set")
  `WSIA_ASSERT(a_dz_zero, !(m_tvalid && m_tdata[131]) || (m_tdata[132] && m_tdata[127:0] == '0),
    "divide by zero without zero result")
  `WSIA_ASSERT(a_stall_src, s_tready || m_tvalid,
    "input stalled with no result waiting")
  `WSIA_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "result changed while stalled")
endmodule
`default_nettype wire

>>> tb/wide_alu_checker.sv
// result checker for the wide signed alu: predicts each result and compares it in order
`default_nettype none
module wide_alu_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [263:0] s_tdata,
  input  wire logic [3:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [135:0] m_tdata,
  output int                n_fail,
  output int                n_pending,
  output int                n_results
);
  typedef struct packed {
    logic         zero;
    logic         dz;
    logic         lt;
    logic         gt;
    logic         eq;
    logic [127:0] val;
  } alu_res_t;

  alu_res_t result_fifo[$];

  // magnitude division by repeated restore, d nonzero
  function automatic void div_mag(input logic [127:0] n, input logic [127:0] d,
                                  output logic [127:0] q, output logic [127:0] r);
    logic [128:0] acc;
    acc = '0;
    q = '0;
    for (int i = 127; i >= 0; i--) begin
      acc = {acc[127:0], n[i]};
      q = q << 1;
      if (acc >= {1'b0, d}) begin
        acc = acc - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    r = acc[127:0];
  endfunction

  function automatic alu_res_t alu_predict(input logic [3:0] op, input logic [127:0] a,
                                           input logic [127:0] b, input logic [6:0] sc);
    alu_res_t o;
    logic [127:0] q, m;
    logic na, nb;
    o = '0;
    na = a[127];
    nb = b[127];
    case (op)
      wsia_pkg::ModeAdd: o.val = a + b;
      wsia_pkg::ModeSub: o.val = a - b;
      wsia_pkg::ModeMul: o.val = a * b;
      wsia_pkg::ModeDiv, wsia_pkg::ModeRem: begin
        if (b == 0) begin
          o.dz = 1'b1;
        end else begin
          div_mag(na ? -a : a, nb ? -b : b, q, m);
          if (op == wsia_pkg::ModeDiv) o.val = (na != nb) ? -q : q;
          else o.val = na ? -m : m;
        end
      end
      wsia_pkg::ModeNeg: o.val = -a;
      wsia_pkg::ModeAnd: o.val = a & b;
      wsia_pkg::ModeOr:  o.val = a | b;
      wsia_pkg::ModeXor: o.val = a ^ b;
      wsia_pkg::ModeNot: o.val = ~a;
      wsia_pkg::ModeShl: o.val = a << sc;
      wsia_pkg::ModeSar: o.val = $signed(a) >>> sc;
      wsia_pkg::ModeRev: for (int i = 0; i < 128; i++) o.val[127-i] = a[i];
      wsia_pkg::ModeCmp: begin
        o.eq = (a == b);
        o.lt = ($signed(a) < $signed(b));
        o.gt = ($signed(a) > $signed(b));
      end
      default: ;
    endcase
    o.zero = (o.val == 0);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    n_fail++;
  endtask

  initial begin
    n_fail = 0;
    n_results = 0;
  end

  assign n_pending = result_fifo.size();

  always @(posedge clk) begin
    alu_res_t w;
    if (!rst && s_tvalid && s_tready)
      result_fifo.push_back(alu_predict(s_tuser, {s_tdata[63:0], s_tdata[127:64]},
                                        {s_tdata[191:128], s_tdata[255:192]},
                                        s_tdata[262:256]));
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (result_fifo.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[127:0], '0);
      end else begin
        w = result_fifo.pop_front();
        if (m_tdata[63:0] != w.val[127:64])
          report_mismatch("result_high", 128'(m_tdata[63:0]), 128'(w.val[127:64]));
        if (m_tdata[127:64] != w.val[63:0])
          report_mismatch("result_low", 128'(m_tdata[127:64]), 128'(w.val[63:0]));
        if (m_tdata[128] != w.eq)
          report_mismatch("is_equal", 128'(m_tdata[128]), 128'(w.eq));
        if (m_tdata[129] != w.gt)
          report_mismatch("is_greater", 128'(m_tdata[129]), 128'(w.gt));
        if (m_tdata[130] != w.lt)
          report_mismatch("is_less", 128'(m_tdata[130]), 128'(w.lt));
        if (m_tdata[131] != w.dz)
          report_mismatch("divide_by_zero", 128'(m_tdata[131]), 128'(w.dz));
        if (m_tdata[132] != w.zero)
          report_mismatch("result_zero", 128'(m_tdata[132]), 128'(w.zero));
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/tb_wide_signed_integer_alu_unit.sv
// stimulus, idling pattern and verdict for the wide signed alu
`default_nettype none
module tb_wide_signed_integer_alu_unit;
  localparam int Latency = 133;
  localparam longint CycleLimit = 400000;
  // the two mode codes left without an operation
  localparam logic [3:0] ModeSpareLo = 4'd14;
  localparam logic [3:0] ModeSpareHi = 4'd15;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [263:0] s_tdata;
  logic [3:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;
  int           n_fail, n_pending, n_results;
  int           send_idle_pct, recv_idle_pct;
  bit           hold_off;
  longint       cycles;

  wide_signed_integer_alu_unit i_dut (.*);

  wide_alu_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .n_fail, .n_pending, .n_results
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb_wide_signed_integer_alu_unit: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off while the pipeline fills
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) m_tready <= 1'b0;
      else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [127:0] rand_operand();
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(7))
      0: v = v >> $urandom_range(127);
      1: v = -(v >> $urandom_range(127));
      2: v = 128'(1) << $urandom_range(127);
      3: v = $urandom_range(3) == 0 ? {1'b1, 127'b0} : 128'($signed($urandom_range(5)) - 2);
      default: ;
    endcase
    return v;
  endfunction

  // valid stays up between items; it drops only on an idle cycle or when draining
  task automatic send_item(input logic [3:0] op, input logic [127:0] a,
                           input logic [127:0] b, input logic [6:0] sc);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, sc, b[63:0], b[127:64], a[63:0], a[127:64]};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  localparam logic [127:0] MinVal = {1'b1, 127'b0};
  localparam logic [127:0] MaxVal = {1'b0, {127{1'b1}}};
  localparam logic [127:0] AllOnes = '1;

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_item(wsia_pkg::ModeAdd, MaxVal, 128'd1, 7'd0);
    send_item(wsia_pkg::ModeSub, MinVal, 128'd1, 7'd0);
    send_item(wsia_pkg::ModeMul, AllOnes, MinVal, 7'd0);
    send_item(wsia_pkg::ModeDiv, 128'd77, 128'd0, 7'd0);
    send_item(wsia_pkg::ModeRem, AllOnes, 128'd0, 7'd0);
    send_item(wsia_pkg::ModeDiv, MinVal, AllOnes, 7'd0);
    send_item(wsia_pkg::ModeRem, MinVal, AllOnes, 7'd0);
    send_item(wsia_pkg::ModeDiv, -128'd7, 128'd2, 7'd0);
    send_item(wsia_pkg::ModeRem, -128'd7, 128'd2, 7'd0);
    send_item(wsia_pkg::ModeRem, 128'd7, -128'd2, 7'd0);
    send_item(wsia_pkg::ModeNeg, MinVal, 128'd0, 7'd0);
    send_item(wsia_pkg::ModeAnd, AllOnes, MaxVal, 7'd0);
    send_item(wsia_pkg::ModeOr, MinVal, 128'd1, 7'd0);
    send_item(wsia_pkg::ModeXor, AllOnes, AllOnes, 7'd0);
    send_item(wsia_pkg::ModeNot, 128'd0, 128'd0, 7'd0);
    send_item(wsia_pkg::ModeShl, AllOnes, 128'd0, 7'd127);
    send_item(wsia_pkg::ModeSar, MinVal, 128'd0, 7'd127);
    send_item(wsia_pkg::ModeSar, MaxVal, 128'd0, 7'd64);
    send_item(wsia_pkg::ModeRev, 128'd1, 128'd0, 7'd0);
    send_item(wsia_pkg::ModeCmp, MinVal, MaxVal, 7'd0);
    send_item(wsia_pkg::ModeCmp, MaxVal, MaxVal, 7'd0);
    send_item(wsia_pkg::ModeCmp, 128'd0, AllOnes, 7'd0);
    send_item(ModeSpareLo, AllOnes, AllOnes, 7'd127);
    send_item(ModeSpareHi, AllOnes, AllOnes, 7'd127);
    drain();

    // long output hold-off with the sender still offering items
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 200; i++)
        send_item(4'($urandom_range(15)), rand_operand(), rand_operand(), 7'($urandom));
    join
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 28 : 0;
      for (int i = 0; i < 150; i++)
        send_item(4'($urandom_range(15)), rand_operand(), rand_operand(), 7'($urandom));
    end

    drain();
    repeat (Latency + 20) @(posedge clk);
    $display("run covered %0d results over all fourteen modes and both unused codes,",
             n_results);
    $display("with divide by zero, overflow wraps, long shifts and a filled pipeline");
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb_wide_signed_integer_alu_unit: PASS");
    end else begin
      $display("tb_wide_signed_integer_alu_unit: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
